// File: sv/varint_length_frame_parser_defines.svh
// Assertion macros shared by the checkers of the frame parser.
// Each expects clk and rst_n in scope.
`ifndef VARINT_LENGTH_FRAME_PARSER_DEFINES_SVH
`define VARINT_LENGTH_FRAME_PARSER_DEFINES_SVH

// same-cycle implication
`define VLFP_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: implication check failed");

// next-cycle implication
`define VLFP_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: next-cycle check failed");

`endif

// File: sv/vlfp_pkg.sv
package vlfp_pkg;

  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned LEN_W    = 32;
  localparam int unsigned VCNT_W   = 3;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned CFG_IDX_W = 2;

  // longest varint in bytes
  localparam logic [VCNT_W-1:0] VARINT_MAX_BYTES = 3'd5;

  localparam logic [CFG_IDX_W-1:0] CFG_EXPECTED_TYPE      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HIGHEST_KNOWN_TYPE = 2'd1;

  localparam logic [BYTE_W-1:0] EXPECTED_TYPE_RST      = 8'd0;
  localparam logic [BYTE_W-1:0] HIGHEST_KNOWN_TYPE_RST = 8'd2;

  localparam logic [STATUS_W-1:0] ST_OK    = 3'd0;
  localparam logic [STATUS_W-1:0] ST_SHORT = 3'd1;
  localparam logic [STATUS_W-1:0] ST_TYPE  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_LEN   = 3'd3;
  localparam logic [STATUS_W-1:0] ST_PAY   = 3'd4;

  typedef enum logic [4:0] {
    PH_TYPE  = 5'b00001,
    PH_LEN   = 5'b00010,
    PH_PAY   = 5'b00100,
    PH_TRAIL = 5'b01000,
    PH_ERR   = 5'b10000
  } phase_t;

  typedef struct packed {
    phase_t               phase;
    logic [VCNT_W-1:0]    vcnt;
    logic [LEN_W-1:0]     len_acc;
    logic [LEN_W-1:0]     pay_cnt;
    logic [BYTE_W-1:0]    held_type;
    logic [STATUS_W-1:0]  pend_err;
  } parse_state_t;

  typedef struct packed {
    logic                 payload_valid;
    logic [BYTE_W-1:0]    payload_data;
    logic [LEN_W-1:0]     declared_length;
    logic [BYTE_W-1:0]    type_code;
    logic                 type_known;
    logic                 message_done;
    logic [STATUS_W-1:0]  frame_status;
  } result_t;

  localparam parse_state_t PARSE_STATE_RST = '{
    phase:     PH_TYPE,
    vcnt:      '0,
    len_acc:   '0,
    pay_cnt:   '0,
    held_type: '0,
    pend_err:  ST_OK
  };

endpackage

// File: sv/vlfp_step.sv
// One parse step: current state and byte in, next state and result out.
module vlfp_step (
  input  vlfp_pkg::parse_state_t       st,
  input  logic [vlfp_pkg::BYTE_W-1:0]  rx_byte,
  input  logic                         end_of_buffer,
  input  logic [vlfp_pkg::BYTE_W-1:0]  expected_type,
  input  logic [vlfp_pkg::BYTE_W-1:0]  highest_known_type,
  output vlfp_pkg::parse_state_t       st_nxt,
  output vlfp_pkg::result_t            res
);
  import vlfp_pkg::*;

  logic                 was_type;
  logic [LEN_W-1:0]     len_part;
  logic [LEN_W-1:0]     acc_upd;
  logic [VCNT_W-1:0]    vcnt_inc;
  logic [LEN_W-1:0]     pay_inc;
  logic [STATUS_W-1:0]  status;
  parse_state_t         upd;

  // 7-bit group placed at 7*count, bits past 31 dropped
  always_comb begin
    case (st.vcnt)
      3'd0:    len_part = {25'd0, rx_byte[6:0]};
      3'd1:    len_part = {18'd0, rx_byte[6:0], 7'd0};
      3'd2:    len_part = {11'd0, rx_byte[6:0], 14'd0};
      3'd3:    len_part = {4'd0, rx_byte[6:0], 21'd0};
      default: len_part = {rx_byte[3:0], 28'd0};
    endcase
  end

  assign acc_upd  = st.len_acc | len_part;
  assign vcnt_inc = st.vcnt + 3'd1;
  assign pay_inc  = st.pay_cnt + 32'd1;

  always_comb begin
    upd                 = st;
    was_type            = 1'b0;
    res.payload_valid   = 1'b0;
    res.payload_data    = '0;
    case (st.phase)
      PH_TYPE: begin
        was_type      = 1'b1;
        upd.held_type = rx_byte;
        if (rx_byte != expected_type) begin
          upd.pend_err = ST_TYPE;
          upd.phase    = PH_ERR;
        end else begin
          upd.phase   = PH_LEN;
          upd.vcnt    = '0;
          upd.len_acc = '0;
        end
      end
      PH_LEN: begin
        upd.len_acc = acc_upd;
        if (!rx_byte[7]) begin
          upd.pay_cnt = '0;
          upd.phase   = (acc_upd == '0) ? PH_TRAIL : PH_PAY;
        end else begin
          upd.vcnt = vcnt_inc;
          if (vcnt_inc >= VARINT_MAX_BYTES) begin
            upd.pend_err = ST_LEN;
            upd.phase    = PH_ERR;
          end
        end
      end
      PH_PAY: begin
        res.payload_valid = 1'b1;
        res.payload_data  = rx_byte;
        upd.pay_cnt       = pay_inc;
        if (pay_inc >= st.len_acc) begin
          upd.phase = PH_TRAIL;
        end
      end
      PH_TRAIL: begin
      end
      default: begin
        upd.phase = PH_ERR;
      end
    endcase

    status = ST_OK;
    if (end_of_buffer) begin
      if (was_type) begin
        status = ST_SHORT;
      end else begin
        case (upd.phase)
          PH_ERR:  status = upd.pend_err;
          PH_LEN:  status = ST_LEN;
          PH_PAY:  status = ST_PAY;
          default: status = ST_OK;
        endcase
      end
    end

    res.declared_length = upd.len_acc;
    res.type_code       = upd.held_type;
    res.type_known      = (upd.held_type <= highest_known_type);
    res.message_done    = end_of_buffer;
    res.frame_status    = status;
  end

  // last byte of the buffer restarts the parse
  assign st_nxt = end_of_buffer ? PARSE_STATE_RST : upd;

endmodule

// File: sv/varint_length_frame_parser.sv
// Length-prefixed message parser. A message is a type byte, a little-endian
// base-128 length (up to 5 bytes, 7 bits each, bit 7 continues), then that
// many payload bytes; bytes past the payload are ignored.
// Input channel: one buffer byte per beat (in_rx_byte), in_end_of_buffer on
// the last byte. Output channel: exactly one result beat per input beat,
// payload bytes flagged by out_payload_valid; the beat for the last byte has
// out_message_done set and the frame status (ok, too short, wrong type, bad
// length, payload short).
// Config channel: cfg_index 0 = expected type, 1 = highest known type; other
// indexes are accepted and dropped. cfg_ready is always high.
// Result valid in the cycle after input accept. Throughput: 1 byte per cycle
// unless stalled; the parse step and output register are the only stage.
// When the receiver stalls, the result holds in the output register and
// in_ready drops until it is taken (in_ready = !out_valid || out_ready).
// Reset (rst_n low, synchronous): parser back to waiting for a type byte,
// registers to expected type 0 and highest known type 2, output empty.
module varint_length_frame_parser (
  input  logic                              clk,
  input  logic                              rst_n,
  // config write channel
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [vlfp_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [vlfp_pkg::BYTE_W-1:0]       cfg_wdata,
  // byte input channel
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [vlfp_pkg::BYTE_W-1:0]       in_rx_byte,
  input  logic                              in_end_of_buffer,
  // result channel
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              out_payload_valid,
  output logic [vlfp_pkg::BYTE_W-1:0]       out_payload_data,
  output logic [vlfp_pkg::LEN_W-1:0]        out_declared_length,
  output logic [vlfp_pkg::BYTE_W-1:0]       out_type_code,
  output logic                              out_type_known,
  output logic                              out_message_done,
  output logic [vlfp_pkg::STATUS_W-1:0]     out_frame_status
);
  import vlfp_pkg::*;

  logic [BYTE_W-1:0] expected_type_r;
  logic [BYTE_W-1:0] highest_known_type_r;
  parse_state_t      state_r;
  parse_state_t      state_nxt;
  result_t           res_nxt;
  result_t           res_r;
  logic              out_valid_r;
  logic              in_beat;

  assign cfg_ready = 1'b1;

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      expected_type_r      <= EXPECTED_TYPE_RST;
      highest_known_type_r <= HIGHEST_KNOWN_TYPE_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_EXPECTED_TYPE:      expected_type_r      <= cfg_wdata;
        CFG_HIGHEST_KNOWN_TYPE: highest_known_type_r <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  // output register frees up when its beat is taken
  assign in_ready = !out_valid_r || out_ready;
  assign in_beat  = in_valid && in_ready;

  vlfp_step u_step (
    .st                 (state_r),
    .rx_byte            (in_rx_byte),
    .end_of_buffer      (in_end_of_buffer),
    .expected_type      (expected_type_r),
    .highest_known_type (highest_known_type_r),
    .st_nxt             (state_nxt),
    .res                (res_nxt)
  );

  // parse state advances once per accepted byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= PARSE_STATE_RST;
    end else if (in_beat) begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_beat) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk) begin
    if (in_beat) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_payload_valid   = res_r.payload_valid;
  assign out_payload_data    = res_r.payload_data;
  assign out_declared_length = res_r.declared_length;
  assign out_type_code       = res_r.type_code;
  assign out_type_known      = res_r.type_known;
  assign out_message_done    = res_r.message_done;
  assign out_frame_status    = res_r.frame_status;

endmodule

// File: sv/vlfp_checker.sv
`include "varint_length_frame_parser_defines.svh"

module vlfp_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_valid,
  input logic                              in_ready,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic                              out_payload_valid,
  input logic [vlfp_pkg::LEN_W-1:0]        out_declared_length,
  input logic                              out_message_done,
  input logic [vlfp_pkg::STATUS_W-1:0]     out_frame_status
);
  import vlfp_pkg::*;

  // a stalled result stays up
  `VLFP_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid)

  // an accepted byte always yields a result next cycle
  `VLFP_ASSERT_NXT(a_one_result, in_valid && in_ready, out_valid)

  // status only on the last beat of a buffer
  `VLFP_ASSERT_IMP(a_status_at_done, out_valid && !out_message_done,
                   out_frame_status == ST_OK)

  // a flagged payload byte needs a nonzero declared length
  `VLFP_ASSERT_IMP(a_pay_len, out_valid && out_payload_valid,
                   out_declared_length != '0)

endmodule

bind varint_length_frame_parser vlfp_checker u_vlfp_checker (.*);
